### rtl/lehmer_pkg.sv
// Shared constants and control types for the Lehmer generator step block.
`timescale 1ns / 1ps

package lehmer_pkg;

  localparam int VALUE_BITS = 31;
  localparam int CNT_BITS   = $clog2(VALUE_BITS);

  localparam logic [VALUE_BITS-1:0] MULT_RESET = VALUE_BITS'(16807);
  localparam logic [VALUE_BITS-1:0] MOD_RESET  = VALUE_BITS'(2147483647);
  localparam logic [VALUE_BITS-1:0] SEED_RESET = VALUE_BITS'(5);

  localparam logic CFG_MULTIPLIER = 1'b0;
  localparam logic CFG_MODULUS    = 1'b1;

  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_S,
    ST_RED_SEED,
    ST_DBL,
    ST_ADD,
    ST_DONE
  } lehmer_state_t;

  typedef struct packed {
    lehmer_state_t state;
    logic          last;
    logic          finish;
  } lehmer_ctrl_t;

endpackage

### rtl/lehmer_prng_step.sv
// Top level: Park-Miller style generator step with one shared modular adder.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_stall   | opcode, seed_value
//   out     | output    | out_valid / out_stall | value
//   cfg     | input     | cfg_write             | cfg_index, cfg_data
//
// An advance makes two remainder passes and a double-and-add pass, one modular add
// per cycle, from accept to result.
// A load makes one remainder pass on seed_value; a modulus below two gives 0.
// in_stall is high from accept until the result enters the output register.
// A stalled result holds; a finished item waits until the output register frees.
// Reset restores multiplier 16807, modulus 2147483647 and current value 5.
`timescale 1ns / 1ps

module lehmer_prng_step (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic [lehmer_pkg::VALUE_BITS-1:0] seed_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lehmer_pkg::VALUE_BITS-1:0] value,
  input  logic                              cfg_write,
  input  logic                              cfg_index,
  input  logic [lehmer_pkg::VALUE_BITS-1:0] cfg_data
);

  localparam int VB = lehmer_pkg::VALUE_BITS;

  logic [VB-1:0] multiplier;
  logic [VB-1:0] modulus;
  logic [VB-1:0] cur_value;
  logic [VB-1:0] acc;
  logic [VB-1:0] src;
  logic [VB-1:0] xop;
  logic [VB-1:0] yop;

  logic [VB-1:0] unit_q;
  logic          unit_cin;
  logic [VB-1:0] unit_r;

  logic mod_small;
  logic out_free;
  logic start;
  lehmer_pkg::lehmer_ctrl_t ctrl;

  assign mod_small = (modulus[VB-1:1] == '0);
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (ctrl.state != lehmer_pkg::ST_IDLE);
  assign start     = in_valid && !in_stall;

  lehmer_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .opcode    (opcode),
    .mod_small (mod_small),
    .out_free  (out_free),
    .ctrl      (ctrl)
  );

  always_comb begin
    unit_q   = '0;
    unit_cin = 1'b0;
    unique case (ctrl.state)
      lehmer_pkg::ST_RED_A, lehmer_pkg::ST_RED_S, lehmer_pkg::ST_RED_SEED: begin
        // shift the next dividend bit into the remainder
        unit_q   = acc;
        unit_cin = src[VB-1];
      end
      lehmer_pkg::ST_DBL: begin
        unit_q = acc;
      end
      lehmer_pkg::ST_ADD: begin
        unit_q = yop[VB-1] ? xop : '0;
      end
      default: begin
        unit_q = '0;
      end
    endcase
  end

  lehmer_addmod u_addmod (
    .p   (acc),
    .q   (unit_q),
    .cin (unit_cin),
    .m   (modulus),
    .r   (unit_r)
  );

  // configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      multiplier <= lehmer_pkg::MULT_RESET;
      modulus    <= lehmer_pkg::MOD_RESET;
      cur_value  <= lehmer_pkg::SEED_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          lehmer_pkg::CFG_MULTIPLIER: multiplier <= cfg_data;
          lehmer_pkg::CFG_MODULUS:    modulus    <= cfg_data;
        endcase
      end
      if (ctrl.finish) begin
        cur_value <= acc;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      value <= acc;
    end
  end

  // datapath working registers
  always_ff @(posedge clk) begin
    unique case (ctrl.state)
      lehmer_pkg::ST_IDLE: begin
        acc <= '0;
        src <= (opcode == lehmer_pkg::OP_LOAD) ? seed_value : multiplier;
      end
      lehmer_pkg::ST_RED_A: begin
        if (ctrl.last) begin
          xop <= unit_r;
          acc <= '0;
          src <= cur_value;
        end else begin
          src <= {src[VB-2:0], 1'b0};
          acc <= unit_r;
        end
      end
      lehmer_pkg::ST_RED_S: begin
        src <= {src[VB-2:0], 1'b0};
        if (ctrl.last) begin
          yop <= unit_r;
          acc <= '0;
        end else begin
          acc <= unit_r;
        end
      end
      lehmer_pkg::ST_RED_SEED: begin
        src <= {src[VB-2:0], 1'b0};
        acc <= unit_r;
      end
      lehmer_pkg::ST_DBL: begin
        acc <= unit_r;
      end
      lehmer_pkg::ST_ADD: begin
        acc <= unit_r;
        yop <= {yop[VB-2:0], 1'b0};
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    (ctrl.state == lehmer_pkg::ST_DBL || ctrl.state == lehmer_pkg::ST_ADD)
      |-> (acc < modulus && xop < modulus))
    else $error("multiply operands not reduced below modulus");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    ctrl.finish |=> (out_valid && value == cur_value))
    else $error("finished beat not presented or state not updated");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !mod_small) |-> (value < modulus))
    else $error("result not below modulus");

  a_small_zero: assert property (@(posedge clk) disable iff (rst)
    (ctrl.finish && mod_small) |-> (acc == '0))
    else $error("small modulus must yield zero");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !ctrl.finish)
    else $error("result overwrote a pending beat");

endmodule

### rtl/lehmer_addmod.sv
// Shared modular add unit: (p + q + cin) mod m for p, q below m.
`timescale 1ns / 1ps

module lehmer_addmod (
  input  logic [lehmer_pkg::VALUE_BITS-1:0] p,
  input  logic [lehmer_pkg::VALUE_BITS-1:0] q,
  input  logic                              cin,
  input  logic [lehmer_pkg::VALUE_BITS-1:0] m,
  output logic [lehmer_pkg::VALUE_BITS-1:0] r
);

  logic [lehmer_pkg::VALUE_BITS:0] sum;
  logic [lehmer_pkg::VALUE_BITS:0] diff;

  always_comb begin
    sum  = {1'b0, p} + {1'b0, q} + {{lehmer_pkg::VALUE_BITS{1'b0}}, cin};
    diff = sum - {1'b0, m};
    if (sum >= {1'b0, m}) begin
      r = diff[lehmer_pkg::VALUE_BITS-1:0];
    end else begin
      r = sum[lehmer_pkg::VALUE_BITS-1:0];
    end
  end

endmodule

### rtl/lehmer_seq.sv
// Sequencer: phase state machine and bit counter for reduce and multiply passes.
`timescale 1ns / 1ps

module lehmer_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      opcode,
  input  logic                      mod_small,
  input  logic                      out_free,
  output lehmer_pkg::lehmer_ctrl_t  ctrl
);

  lehmer_pkg::lehmer_state_t state, state_next;
  logic [lehmer_pkg::CNT_BITS-1:0] cnt, cnt_next;
  logic last;

  assign last = (cnt == lehmer_pkg::CNT_BITS'(lehmer_pkg::VALUE_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lehmer_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    ctrl.state  = state;
    ctrl.last   = last;
    ctrl.finish = 1'b0;
    unique case (state)
      lehmer_pkg::ST_IDLE: begin
        cnt_next = '0;
        if (start) begin
          if (mod_small) begin
            state_next = lehmer_pkg::ST_DONE;
          end else if (opcode == lehmer_pkg::OP_LOAD) begin
            state_next = lehmer_pkg::ST_RED_SEED;
          end else begin
            state_next = lehmer_pkg::ST_RED_A;
          end
        end
      end
      lehmer_pkg::ST_RED_A: begin
        cnt_next = last ? '0 : cnt + 1'b1;
        if (last) state_next = lehmer_pkg::ST_RED_S;
      end
      lehmer_pkg::ST_RED_S: begin
        cnt_next = last ? '0 : cnt + 1'b1;
        if (last) state_next = lehmer_pkg::ST_DBL;
      end
      lehmer_pkg::ST_RED_SEED: begin
        cnt_next = last ? '0 : cnt + 1'b1;
        if (last) state_next = lehmer_pkg::ST_DONE;
      end
      lehmer_pkg::ST_DBL: begin
        state_next = lehmer_pkg::ST_ADD;
      end
      lehmer_pkg::ST_ADD: begin
        cnt_next = last ? '0 : cnt + 1'b1;
        state_next = last ? lehmer_pkg::ST_DONE : lehmer_pkg::ST_DBL;
      end
      lehmer_pkg::ST_DONE: begin
        // hold the result until the output register is free
        if (out_free) begin
          ctrl.finish = 1'b1;
          state_next  = lehmer_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lehmer_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
